// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define RDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rdq assertion failed");

// next-cycle implication, checked out of reset
`define RDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rdq assertion failed");

`endif

// ----- rtl/rdq_pkg.sv -----
`timescale 1ns / 1ps

package rdq_pkg;

    // field widths fixed by the stream format
    localparam int VALUE_IN_BITS  = 16;
    localparam int COUNT_BITS     = 11;
    localparam int OUT_PAD_BITS   = 5;
    localparam int OUT_TDATA_BITS = VALUE_IN_BITS + COUNT_BITS + OUT_PAD_BITS;

    // action codes as carried on the input tuser
    typedef enum logic [2:0] {
        ACT_CLEAR   = 3'd0,
        ACT_LOAD    = 3'd1,
        ACT_REVERSE = 3'd2,
        ACT_DELETE  = 3'd3,
        ACT_READ    = 3'd4,
        ACT_NOP     = 3'd5
    } t_act;

    // result status codes as carried on the output tuser
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ERROR      = 2'd1,
        ST_EMPTY_READ = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    // classified command from the front queue
    typedef struct packed {
        t_act                     act;
        logic [VALUE_IN_BITS-1:0] value;
    } t_cmd;

    // result fields waiting on the memory read
    typedef struct packed {
        t_status               status;
        logic                  last;
        logic [COUNT_BITS-1:0] count;
        logic                  use_rdata;
    } t_res;

endpackage

// ----- rtl/rdq_front.sv -----
`timescale 1ns / 1ps

module rdq_front
    import rdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_tvalid,
    output logic                     o_tready,
    input  logic [VALUE_IN_BITS-1:0] i_tdata,
    input  logic [2:0]               i_tuser,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_cmd                     o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    t_act       w_act;
    logic       w_push;
    logic       w_pop;

    // classify the action code, unused codes become no-ops
    always_comb begin
        if (i_tuser <= ACT_READ) begin
            w_act = t_act'(i_tuser);
        end else begin
            w_act = ACT_NOP;
        end
    end

    assign o_tready = (r_fill != 2'd2);
    assign o_valid  = (r_fill != 2'd0);
    assign o_cmd    = r_q[r_rp];
    assign w_push   = i_tvalid && o_tready;
    assign w_pop    = o_valid && i_ready;

    // two-entry command queue, payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{act: w_act, value: i_tdata};
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/rdq_back.sv -----
`timescale 1ns / 1ps

module rdq_back
    import rdq_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  t_cmd                          i_cmd,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [OUT_TDATA_BITS-1:0]     o_tdata,
    output logic [1:0]                    o_tuser,
    output logic                          o_tlast,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic [$clog2(DEPTH+1)-1:0]    o_cursor
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int KEEP = (VALUE_BITS < VALUE_IN_BITS) ? VALUE_BITS : VALUE_IN_BITS;

    // ring position, head plus offset wrapped once
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] head,
                                           input logic [CW-1:0] offset);
        logic [AW:0] sum;
        sum = (AW + 1)'(head) + (AW + 1)'(offset);
        if (sum >= (AW + 1)'(DEPTH)) begin
            sum = sum - (AW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [VALUE_BITS-1:0]    r_mem [DEPTH];
    logic [VALUE_BITS-1:0]    r_rdata;
    logic [AW-1:0]            r_head;
    logic [CW-1:0]            r_cnt;
    logic                     r_rev;
    logic                     r_err;
    logic [CW-1:0]            r_cur;
    logic                     r_p1_valid;
    t_res                     r_p1;
    logic                     r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_tdata;
    logic [1:0]               r_out_tuser;
    logic                     r_out_tlast;

    logic [AW-1:0]            n_head;
    logic [CW-1:0]            n_cnt;
    logic                     n_rev;
    logic                     n_err;
    logic [CW-1:0]            n_cur;

    logic                     w_fire;
    logic                     w_p1_move;
    logic [CW-1:0]            w_logical;
    logic [CW-1:0]            w_offset;
    logic [AW-1:0]            w_pos;
    logic                     w_we;
    logic                     w_re;
    logic [VALUE_BITS-1:0]    w_wdata;
    t_res                     w_res;
    logic [VALUE_IN_BITS-1:0] w_rval;

    assign w_p1_move = r_p1_valid && (!r_out_valid || i_tready);
    assign o_ready   = !r_p1_valid || w_p1_move;
    assign w_fire    = i_valid && o_ready;

    // ring position for the one memory access of this action
    assign w_logical = r_rev ? (r_cnt - CW'(1) - r_cur) : r_cur;

    always_comb begin
        unique case (i_cmd.act)
            ACT_LOAD:   w_offset = r_cnt;
            ACT_DELETE: w_offset = CW'(1);
            default:    w_offset = w_logical;
        endcase
    end

    assign w_pos = wrap(r_head, w_offset);

    // stored value kept in the configured width
    always_comb begin
        w_wdata = '0;
        w_wdata[KEEP-1:0] = i_cmd.value[KEEP-1:0];
    end

    // execute the action against the deque state
    always_comb begin
        n_head          = r_head;
        n_cnt           = r_cnt;
        n_rev           = r_rev;
        n_err           = r_err;
        n_cur           = r_cur;
        w_we            = 1'b0;
        w_re            = 1'b0;
        w_res.status    = ST_OK;
        w_res.last      = 1'b0;
        w_res.use_rdata = 1'b0;
        if (i_cmd.act == ACT_CLEAR) begin
            n_head = '0;
            n_cnt  = '0;
            n_rev  = 1'b0;
            n_err  = 1'b0;
            n_cur  = '0;
        end else if (r_err) begin
            w_res.status = ST_ERROR;
        end else begin
            unique case (i_cmd.act)
                ACT_LOAD: begin
                    if (r_cnt == CW'(DEPTH)) begin
                        w_res.status = ST_FULL;
                    end else begin
                        w_we  = 1'b1;
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                ACT_REVERSE: begin
                    n_rev = ~r_rev;
                    n_cur = '0;
                end
                ACT_DELETE: begin
                    if (r_cnt == '0) begin
                        n_err        = 1'b1;
                        w_res.status = ST_ERROR;
                    end else begin
                        if (!r_rev) begin
                            n_head = w_pos;
                        end
                        n_cnt = r_cnt - CW'(1);
                        n_cur = '0;
                    end
                end
                ACT_READ: begin
                    if (r_cur < r_cnt) begin
                        w_re            = 1'b1;
                        w_res.use_rdata = 1'b1;
                        w_res.last      = (r_cur == r_cnt - CW'(1));
                        n_cur           = r_cur + CW'(1);
                    end else begin
                        w_res.status = ST_EMPTY_READ;
                    end
                end
                default: begin
                end
            endcase
        end
        w_res.count = COUNT_BITS'(n_cnt);
    end

    // deque state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
            r_rev  <= 1'b0;
            r_err  <= 1'b0;
            r_cur  <= '0;
        end else if (w_fire) begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
            r_rev  <= n_rev;
            r_err  <= n_err;
            r_cur  <= n_cur;
        end
    end

    // element memory, one access per action
    always_ff @(posedge i_clk) begin
        if (w_fire && w_we) begin
            r_mem[w_pos] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_re) begin
            r_rdata <= r_mem[w_pos];
        end
    end

    // stage waiting on the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (w_fire) begin
            r_p1_valid <= 1'b1;
        end else if (w_p1_move) begin
            r_p1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_p1 <= w_res;
        end
    end

    // read value in the output width, zero when no read
    always_comb begin
        w_rval = '0;
        if (r_p1.use_rdata) begin
            w_rval[KEEP-1:0] = r_rdata[KEEP-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_p1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p1_move) begin
            r_out_tdata <= {{OUT_PAD_BITS{1'b0}}, r_p1.count, w_rval};
            r_out_tuser <= r_p1.status;
            r_out_tlast <= r_p1.last;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_tdata;
    assign o_tuser  = r_out_tuser;
    assign o_tlast  = r_out_tlast;
    assign o_count  = r_cnt;
    assign o_cursor = r_cur;

endmodule

// ----- rtl/reversible_deque_with_delete.sv -----
// path: an action passes the command queue, the read-data stage and the output register
// throughput: one action per cycle while the output is not stalled, set by the single port of the element ring
// memory and the execute stage that updates head, count, cursor and flags
// reset: synchronous, active low; clears pointers, flags, queue and pipeline valids
// the element memory is not cleared, no clearing pass; the block is ready at once
`timescale 1ns / 1ps
`include "assert_macros.svh"

module reversible_deque_with_delete
    import rdq_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [VALUE_IN_BITS-1:0]  s_axis_tdata,   // load_value
    input  logic [2:0]                s_axis_tuser,   // action
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // read_value, element_count, zero pad
    output logic [1:0]                m_axis_tuser,   // status
    output logic                      m_axis_tlast    // read_last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic          w_q_valid;
    logic          w_q_ready;
    t_cmd          w_q_cmd;
    logic [CW-1:0] w_count;
    logic [CW-1:0] w_cursor;

    // accept and classify
    rdq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_valid  (w_q_valid),
        .i_ready  (w_q_ready),
        .o_cmd    (w_q_cmd)
    );

    // execute against the ring memory
    rdq_back #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_cmd    (w_q_cmd),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast),
        .o_count  (w_count),
        .o_cursor (w_cursor)
    );

    // checks
    `RDQ_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, w_count <= CW'(DEPTH))
    `RDQ_ASSERT_NOW(a_cursor_le_count, i_clk, i_rst_n, 1'b1, w_cursor <= w_count)
    `RDQ_ASSERT_NOW(a_last_only_on_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == ST_OK)
    `RDQ_ASSERT_NOW(a_value_only_on_ok, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[VALUE_IN_BITS-1:0] != '0), m_axis_tuser == ST_OK)

endmodule
